[rtl/fec_arq_receiver_tracker_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the receiver tracker
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FEC_ARQ_RECEIVER_TRACKER_CORE_ASSERT_SVH
`define FEC_ARQ_RECEIVER_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FARQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("farq: check failed");
`define FARQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("farq: check failed");
`else
`define FARQ_ASSERT_IMP(lbl, ante, cons)
`define FARQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/farq_pkg.sv]
// ----------------------------------------------------------------------------
// farq_pkg
// Codes, widths, reset values and types shared by the receiver tracker.
// ----------------------------------------------------------------------------
package farq_pkg;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 10;
  localparam int OFFS_W   = 14;
  localparam int GAP_W    = 14;
  localparam int LIM_W    = 2;
  localparam int CFG_W    = 14;

  localparam logic [1:0] KIND_RED  = 2'd0;
  localparam logic [1:0] KIND_RES  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] ACT_FWD_CUR = 2'd0;
  localparam logic [1:0] ACT_FWD_PRV = 2'd1;
  localparam logic [1:0] ACT_FWD_RES = 2'd2;
  localparam logic [1:0] ACT_NACK    = 2'd3;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_GAP    = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd20;
  localparam logic [OFFS_W-1:0]   OFFSET_RST = 14'd35;
  localparam logic [GAP_W-1:0]    GAP_RST    = 14'd25;
  localparam logic [LIM_W-1:0]    LIMIT_RST  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] last_ms;
    logic [1:0]        cnt;
    logic              rcv;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_ARD   = 14'b00000000001000,
    S_ACHK  = 14'b00000000010000,
    S_P1RD  = 14'b00000000100000,
    S_P1CHK = 14'b00000001000000,
    S_P2RD  = 14'b00000010000000,
    S_P2CHK = 14'b00000100000000,
    S_PKRD  = 14'b00001000000000,
    S_PKCHK = 14'b00010000000000,
    S_PVRD  = 14'b00100000000000,
    S_PVCHK = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

endpackage

[rtl/farq_ram.sv]
// ----------------------------------------------------------------------------
// farq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module farq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/farq_div.sv]
// ----------------------------------------------------------------------------
// farq_div
// Restoring divider, one quotient bit per cycle, for the expected frame.
// ----------------------------------------------------------------------------
module farq_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [farq_pkg::TIME_W-1:0]    dividend,
  input  logic [farq_pkg::PERIOD_W-1:0]  divisor,
  output logic                           busy,
  output logic                           done,
  output logic [farq_pkg::TIME_W-1:0]    quotient
);
  import farq_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic [STEP_W-1:0]   step_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] dvs_r;
  logic [TIME_W-1:0]   quo_r;
  logic                busy_r;
  logic                done_r;
  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W+1:0] trial;

  assign shifted = {rem_r, quo_r[TIME_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!trial[PERIOD_W+1]) begin
          rem_r <= trial[PERIOD_W-1:0];
          quo_r <= {quo_r[TIME_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[PERIOD_W-1:0];
          quo_r <= {quo_r[TIME_W-2:0], 1'b0};
        end
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/fec_arq_receiver_tracker_core.sv]
// ----------------------------------------------------------------------------
// fec_arq_receiver_tracker_core
// Selective-repeat NACK receiver bookkeeping over a per-frame table.
// ----------------------------------------------------------------------------
// After reset the block sweeps its frame table, one entry per cycle, and
// clears all SEQ_SPACE entries before it takes the first item. Every table
// access goes through the table RAM, whose read data is registered, so each
// examined entry takes a read state and a check state. A packet item checks
// its own entry and, for a redundant item, the one before it, and may stall
// on the output. A tick item advances the first gap and runs the gap scan;
// a known start time adds the serial divider first and the retry scan last.
`include "fec_arq_receiver_tracker_core_assert.svh"

module fec_arq_receiver_tracker_core #(
  parameter int SEQ_SPACE  = 65536,
  parameter int NACK_BURST = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [55:0]                 in_tdata,  // seq, elapsed_ms, time_known
  input  logic [1:0]                  in_tuser,  // kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata, // frame_seq
  output logic [1:0]                  out_tuser, // action
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_addr,
  input  logic [farq_pkg::CFG_W-1:0]  cfg_data
);
  import farq_pkg::*;

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int IDX_W = SEQ_W + 1;
  localparam int CNT_W = $clog2(NACK_BURST + 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    fg_r, fg_nxt;
  logic [CNT_W-1:0]    nn_r, nn_nxt;
  logic                hs_v_r;
  logic [SEQ_W-1:0]    hs_r;
  logic                cm_v_r;
  logic [SEQ_W-1:0]    cm_r;
  logic [1:0]          kind_r;
  logic [TIME_W-1:0]   now_r;
  logic                tk_r;
  logic                dneg_r;
  logic [PERIOD_W-1:0] period_r;
  logic [OFFS_W-1:0]   offset_r;
  logic [GAP_W-1:0]    gap_r;
  logic [LIM_W-1:0]    limit_r;
  logic                pend_v_r;
  logic [1:0]          pend_act_r;
  logic [SEQ_W-1:0]    pend_seq_r;
  logic                out_v_r;
  logic [1:0]          out_act_r;
  logic [SEQ_W-1:0]    out_seq_r;
  logic                out_last_r;

  logic                in_fire;
  logic [1:0]          in_kind;
  logic [15:0]         in_seq;
  logic [TIME_W-1:0]   in_now;
  logic                in_tk;
  logic [TIME_W:0]     diff;
  logic [TIME_W:0]     diff_neg;
  logic [TIME_W-1:0]   mag;
  logic [PERIOD_W-1:0] divisor;
  logic                div_busy;
  logic                div_done;
  logic [TIME_W-1:0]   div_quo;
  logic [SEQ_W-1:0]    q_clamp;

  logic                ram_we;
  logic [SEQ_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              rd_q;
  logic [ENTRY_W-1:0]  rd_raw;

  logic                out_free;
  logic                can_emit;
  logic                em_v;
  logic [1:0]          em_act;
  logic                fin_push;
  logic                push_v;
  logic                p2_elig;
  logic [TIME_W-1:0]   since;

  assign in_kind = in_tuser;
  assign in_seq  = in_tdata[15:0];
  assign in_now  = in_tdata[47:16];
  assign in_tk   = in_tdata[48];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign diff     = {1'b0, in_now} - {{(TIME_W+1-OFFS_W){1'b0}}, offset_r};
  assign diff_neg = '0 - diff;
  assign mag      = diff[TIME_W] ? diff_neg[TIME_W-1:0] : diff[TIME_W-1:0];
  assign divisor  = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign q_clamp  = (div_quo > TIME_W'(SEQ_SPACE - 1)) ? SEQ_W'(SEQ_SPACE - 1)
                                                       : div_quo[SEQ_W-1:0];

  farq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && in_kind == KIND_TICK && in_tk),
    .dividend (mag),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  farq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEQ_SPACE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[SEQ_W-1:0]),
    .rdata (rd_raw)
  );

  assign rd_q     = entry_t'(rd_raw);
  assign out_free = !out_v_r || out_tready;
  assign can_emit = !pend_v_r || out_free;
  assign since    = now_r - rd_q.last_ms;
  assign p2_elig  = !rd_q.rcv && (rd_q.cnt < limit_r) &&
                    ((rd_q.cnt == 2'd0) ||
                     ((now_r > rd_q.last_ms) && (since > TIME_W'(gap_r))));
  assign push_v   = (em_v && pend_v_r) || fin_push;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fg_nxt    = fg_r;
    nn_nxt    = nn_r;
    em_v      = 1'b0;
    em_act    = ACT_NACK;
    fin_push  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r[SEQ_W-1:0];
    ram_wdata = rd_q;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IDX_W'(SEQ_SPACE - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          nn_nxt = '0;
          case (in_kind) inside
            KIND_RED, KIND_RES: begin
              if ({1'b0, in_seq} >= 17'(SEQ_SPACE)) begin
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = IDX_W'(in_seq);
                state_nxt = S_PKRD;
              end
            end
            KIND_TICK: begin
              idx_nxt   = fg_r;
              state_nxt = in_tk ? S_DIV : S_ARD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        if (idx_r == IDX_W'(SEQ_SPACE)) begin
          idx_nxt   = fg_r;
          state_nxt = S_P1RD;
        end else begin
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (rd_q.rcv) begin
          fg_nxt    = fg_r + 1'b1;
          idx_nxt   = fg_r + 1'b1;
          state_nxt = S_ARD;
        end else begin
          idx_nxt   = fg_r;
          state_nxt = S_P1RD;
        end
      end
      S_P1RD: begin
        if (hs_v_r && idx_r < {1'b0, hs_r} && nn_r < CNT_W'(NACK_BURST)) begin
          state_nxt = S_P1CHK;
        end else if (tk_r) begin
          idx_nxt   = fg_r;
          state_nxt = S_P2RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_P1CHK: begin
        if (!rd_q.rcv && rd_q.cnt == 2'd0) begin
          if (can_emit) begin
            em_v      = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = '{last_ms: now_r, cnt: 2'd1, rcv: 1'b0};
            nn_nxt    = nn_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_P1RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P1RD;
        end
      end
      S_P2RD: begin
        if (cm_v_r && idx_r <= {1'b0, cm_r} && nn_r < CNT_W'(NACK_BURST)) begin
          state_nxt = S_P2CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_P2CHK: begin
        if (p2_elig) begin
          if (can_emit) begin
            em_v      = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = '{last_ms: now_r, cnt: rd_q.cnt + 2'd1, rcv: 1'b0};
            nn_nxt    = nn_r + 1'b1;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_P2RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_P2RD;
        end
      end
      S_PKRD: state_nxt = S_PKCHK;
      S_PKCHK: begin
        if (!rd_q.rcv && !can_emit) begin
          state_nxt = S_PKCHK;
        end else begin
          if (!rd_q.rcv) begin
            em_v          = 1'b1;
            em_act        = (kind_r == KIND_RED) ? ACT_FWD_CUR : ACT_FWD_RES;
            ram_we        = 1'b1;
            ram_wdata.rcv = 1'b1;
          end
          if (kind_r == KIND_RED && idx_r != '0) begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_PVRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PVRD: state_nxt = S_PVCHK;
      S_PVCHK: begin
        if (!rd_q.rcv) begin
          if (can_emit) begin
            em_v          = 1'b1;
            em_act        = ACT_FWD_PRV;
            ram_we        = 1'b1;
            ram_wdata.rcv = 1'b1;
            state_nxt     = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          fin_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      idx_r    <= '0;
      fg_r     <= '0;
      nn_r     <= '0;
      hs_v_r   <= 1'b0;
      hs_r     <= '0;
      cm_v_r   <= 1'b0;
      cm_r     <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      period_r <= PERIOD_RST;
      offset_r <= OFFSET_RST;
      gap_r    <= GAP_RST;
      limit_r  <= LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fg_r    <= fg_nxt;
      nn_r    <= nn_nxt;
      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
          REG_OFFSET: offset_r <= cfg_data[OFFS_W-1:0];
          REG_GAP:    gap_r    <= cfg_data[GAP_W-1:0];
          REG_LIMIT:  limit_r  <= cfg_data[LIM_W-1:0];
          default:    limit_r  <= limit_r;
        endcase
      end
      if (state_r == S_PKRD && (!hs_v_r || idx_r[SEQ_W-1:0] > hs_r)) begin
        hs_v_r <= 1'b1;
        hs_r   <= idx_r[SEQ_W-1:0];
      end
      if (state_r == S_IDLE && in_fire && in_kind == KIND_TICK) begin
        cm_v_r <= 1'b0;
      end else if (div_done) begin
        if (dneg_r) begin
          cm_v_r <= hs_v_r || (div_quo == '0);
          cm_r   <= hs_v_r ? hs_r : '0;
        end else begin
          cm_v_r <= 1'b1;
          cm_r   <= (hs_v_r && hs_r > q_clamp) ? hs_r : q_clamp;
        end
      end
      if (em_v) begin
        pend_v_r <= 1'b1;
      end else if (fin_push) begin
        pend_v_r <= 1'b0;
      end
      if (push_v) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      now_r  <= in_now;
      tk_r   <= in_tk;
      dneg_r <= diff[TIME_W];
    end
    if (em_v) begin
      pend_act_r <= em_act;
      pend_seq_r <= idx_r[SEQ_W-1:0];
    end
    if (push_v) begin
      out_act_r  <= pend_act_r;
      out_seq_r  <= pend_seq_r;
      out_last_r <= fin_push;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = 16'(out_seq_r);
  assign out_tlast  = out_last_r;

  `FARQ_ASSERT_IMP(a_ready_no_pending, in_tready, !pend_v_r)
  `FARQ_ASSERT_IMP(a_burst_cap, 1'b1, nn_r <= CNT_W'(NACK_BURST))
  `FARQ_ASSERT_IMP(a_div_in_tick, div_busy, state_r == S_DIV)
  `FARQ_ASSERT_NXT(a_emit_held, em_v, pend_v_r)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Receiver tracker testbench
// Drives packet, tick and unknown-kind items into the tracker and checks
// every forward and NACK result against a cycle-free model of the frame
// table; both streams idle at random, under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import farq_pkg::*;

  localparam int SPACE = 65536;
  localparam int BURST = 64;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] frame_seq;
    logic        last;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [CFG_W-1:0] cfg_data;

  fec_arq_receiver_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow of the frame table and registers.
  bit               rcv_map [SPACE];
  bit [1:0]         nack_cnt [SPACE];
  int unsigned      nack_ms [SPACE];
  int               top_seq;
  int               gap_ptr;
  logic [PERIOD_W-1:0] period_ms;
  logic [OFFS_W-1:0]   offset_ms;
  logic [GAP_W-1:0]    retry_ms;
  logic [LIM_W-1:0]    limit;

  frame_result_t expected_q[$];
  int  mismatches;
  int  idle_cycles;
  bit  quiet;
  int  next_seq;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_result(logic [1:0] act, int s);
    frame_result_t r;
    r.action = act;
    r.frame_seq = s[15:0];
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void track_item(logic [1:0] kind, int s, int unsigned now, bit tk);
    int n;
    int unsigned p;
    longint d;
    longint q;
    longint cm;
    n = 0;
    if (kind == KIND_RED || kind == KIND_RES) begin
      if (!rcv_map[s]) begin
        rcv_map[s] = 1'b1;
        push_result(kind == KIND_RED ? ACT_FWD_CUR : ACT_FWD_RES, s);
        n++;
      end
      if (kind == KIND_RED && s > 0 && !rcv_map[s-1]) begin
        rcv_map[s-1] = 1'b1;
        push_result(ACT_FWD_PRV, s - 1);
        n++;
      end
      if (s > top_seq) top_seq = s;
    end else if (kind == KIND_TICK) begin
      while (gap_ptr < SPACE && rcv_map[gap_ptr]) gap_ptr++;
      for (int i = gap_ptr; i < top_seq && i < SPACE && n < BURST; i++) begin
        if (!rcv_map[i] && nack_cnt[i] == 0) begin
          push_result(ACT_NACK, i);
          n++;
          nack_ms[i] = now;
          nack_cnt[i] = 2'd1;
        end
      end
      if (tk) begin
        p = (period_ms != 0) ? period_ms : 1;
        d = longint'(now) - longint'(offset_ms);
        q = (d >= 0) ? d / p : -((-d) / p);
        cm = (top_seq > q) ? top_seq : q;
        if (cm > SPACE - 1) cm = SPACE - 1;
        for (int i = gap_ptr; i <= cm && n < BURST; i++) begin
          if (rcv_map[i] || nack_cnt[i] >= limit) continue;
          if (nack_cnt[i] != 0 && !(now > nack_ms[i] && now - nack_ms[i] > retry_ms))
            continue;
          push_result(ACT_NACK, i);
          n++;
          nack_ms[i] = now;
          nack_cnt[i] = nack_cnt[i] + 2'd1;
        end
      end
    end
    if (n > 0) expected_q[$].last = 1'b1;
  endfunction

  task automatic send_item(logic [1:0] kind, int s, int unsigned now, bit tk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, tk, now, s[15:0]};
    do @(posedge clk); while (!in_tready);
    track_item(kind, s, now, tk);
  endtask

  task automatic write_reg(logic [1:0] addr, int unsigned value);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      REG_PERIOD: period_ms = value[PERIOD_W-1:0];
      REG_OFFSET: offset_ms = value[OFFS_W-1:0];
      REG_GAP:    retry_ms  = value[GAP_W-1:0];
      REG_LIMIT:  limit     = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // The sender holds off until every result is back and the settle wait is over.
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(int unsigned p, int unsigned o, int unsigned g, int unsigned l);
    drain();
    write_reg(REG_PERIOD, p);
    write_reg(REG_OFFSET, o);
    write_reg(REG_GAP, g);
    write_reg(REG_LIMIT, l);
  endtask

  task automatic test_default_flow();
    send_item(KIND_RED, 0, 0, 0);
    send_item(KIND_RED, 0, 0, 0);
    send_item(KIND_RES, 3, 0, 0);
    send_item(KIND_RED, 5, 0, 0);
    send_item(KIND_TICK, 0, 32'd0, 0);
    send_item(KIND_TICK, 0, 32'd100, 1);
    send_item(KIND_TICK, 0, 32'd50, 1);
    send_item(KIND_NONE, 7, 32'd200, 1);
    send_item(KIND_RES, 1, 0, 0);
    send_item(KIND_TICK, 0, 32'd400, 1);
    send_item(KIND_RED, 2, 0, 0);
    next_seq = 10;
  endtask

  task automatic test_register_extremes();
    configure(1000, 10000, 0, 3);
    send_item(KIND_RED, 12, 0, 0);
    send_item(KIND_TICK, 0, 32'd5000, 1);
    send_item(KIND_TICK, 0, 32'd5001, 1);
    send_item(KIND_TICK, 0, 32'd5001, 1);
    send_item(KIND_TICK, 0, 32'd13000, 1);
    configure(0, 0, 10000, 0);
    send_item(KIND_RED, 20, 0, 0);
    send_item(KIND_TICK, 0, 32'd30, 1);
    send_item(KIND_TICK, 0, 32'd90, 0);
    configure(1, 0, 10000, 1);
    send_item(KIND_TICK, 0, 32'd40, 1);
    send_item(KIND_TICK, 0, 32'd20000, 1);
    next_seq = 25;
  endtask

  task automatic test_random_stream(int items);
    int unsigned now;
    int unsigned p;
    int r;
    p = (period_ms != 0) ? period_ms : 1;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 6) == 0) next_seq += $urandom_range(1, 3);
        send_item($urandom_range(0, 9) < 7 ? KIND_RED : KIND_RES, next_seq, $urandom, 0);
        next_seq++;
      end else if (r < 67) begin
        send_item($urandom_range(0, 1) ? KIND_RED : KIND_RES,
                  $urandom_range(0, next_seq), $urandom, 0);
      end else if (r < 92) begin
        now = offset_ms + next_seq * p + $urandom_range(0, 3 * p);
        if ($urandom_range(0, 7) == 0) now = now - $urandom_range(0, 2 * p);
        send_item(KIND_TICK, $urandom, now, $urandom_range(0, 4) != 0);
      end else if (r < 96) begin
        send_item(KIND_NONE, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
        send_item(KIND_TICK, $urandom, $urandom, 0);
      end
    end
  endtask

  task automatic test_top_of_space();
    send_item(KIND_RED, 65535, 32'hFFFF_FFFF, 1);
    send_item(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1);
    send_item(KIND_RES, 32768, 32'hAAAA_5555, 1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_RED;
    cfg_valid = 1'b0;
    cfg_addr = REG_PERIOD;
    cfg_data = '0;
    mismatches = 0;
    quiet = 1'b0;
    top_seq = -1;
    gap_ptr = 0;
    period_ms = PERIOD_RST;
    offset_ms = OFFSET_RST;
    retry_ms = GAP_RST;
    limit = LIMIT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_default_flow();
    test_register_extremes();
    configure(20, 35, 25, 2);
    test_random_stream(120);
    configure(7, 3, 0, 3);
    test_random_stream(80);
    quiet = 1'b1;
    test_random_stream(50);
    test_top_of_space();
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    out_tready = 1'b1;
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: action %0d frame_seq %0d", out_tuser, out_tdata);
        mismatches++;
      end else begin
        frame_result_t e;
        e = expected_q.pop_front();
        if (out_tuser !== e.action) begin
          $error("action: expected %0d, got %0d", e.action, out_tuser);
          mismatches++;
        end
        if (out_tdata !== e.frame_seq) begin
          $error("frame_seq: expected %0d, got %0d", e.frame_seq, out_tdata);
          mismatches++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
